[sv/mer_pkg.sv]
// Shared types and codes for the midpoint ellipse rasterizer.
package mer_pkg;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [9:0] semi_major;
    logic [9:0] semi_minor;
    logic [9:0] center_x;
    logic [9:0] center_y;
  } in_item_t;

  typedef struct packed {
    logic signed [11:0] pixel_x;
    logic signed [11:0] pixel_y;
    logic               last_of_set;
    logic               done_res;
  } out_item_t;

  typedef enum logic [1:0] {
    RG_NONE,
    RG_ONE,
    RG_TWO
  } region_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_SQ_A,
    DP_SQ_B,
    DP_AAB,
    DP_INIT1,
    DP_INIT2,
    DP_RND,
    DP_R1_MOVE,
    DP_TR_LATCH,
    DP_TR_M1,
    DP_TR_M2,
    DP_TR_M3,
    DP_TR_M4,
    DP_TR_M5,
    DP_TRUNC,
    DP_DEC_BB,
    DP_DEC_AA,
    DP_DEC_GX,
    DP_DEC_GY,
    DP_R2_MOVE,
    DP_LATCH
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_AAB,
    ST_INIT1,
    ST_INIT2,
    ST_RND,
    ST_R1_CHK,
    ST_R1_BB,
    ST_R1_GX,
    ST_R1_GY,
    ST_TR_M1,
    ST_TR_M2,
    ST_TR_M3,
    ST_TR_M4,
    ST_TR_M5,
    ST_TR_TRUNC,
    ST_R2_MOVE,
    ST_R2_AA,
    ST_R2_GX,
    ST_R2_GY,
    ST_LATCH,
    ST_EMIT0,
    ST_EMIT1,
    ST_EMIT2,
    ST_EMIT3
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t     op;
    logic       emit;
    logic [1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic gx_lt_gy;
    logic dec_neg;
    logic y_zero;
    logic set_done;
    logic out_free;
  } dp_status_t;

endpackage

[sv/mer_datapath.sv]
// Datapath of the ellipse rasterizer: walk registers, shared multiplier, decision adder, output.
module mer_datapath import mer_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  localparam int G      = (COORD_BITS < 10) ? COORD_BITS : 10;
  localparam int X_W    = G + 1;
  localparam int AA_W   = 2 * G;
  localparam int GRAD_W = 3 * G + 3;
  localparam int MUL_W  = 2 * G + 4;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DEC_W  = 4 * G + 8;

  logic [G-1:0]             a_r;
  logic [G-1:0]             cx_r, cy_r;
  logic [X_W-1:0]           x_r, y_r;
  logic [AA_W-1:0]          aa_r, bb_r;
  logic [GRAD_W-1:0]        gx_r, gy_r;
  logic signed [DEC_W-1:0]  dec_r, dec_nxt;
  logic [PROD_W-1:0]        prod_r;
  logic                     dneg_r;
  logic [11:0]              xp_r, xm_r, yp_r, ym_r;
  logic                     done_r;
  logic                     out_valid_r;
  out_item_t                out_data_r;

  logic [MUL_W-1:0]         mul_a, mul_b;
  logic [PROD_W-1:0]        mul_p;
  logic [X_W:0]             tx;
  logic [X_W-1:0]           ty;
  logic signed [DEC_W-1:0]  rnd_sum;
  logic [GRAD_W-1:0]        two_bb, two_aa;
  logic                     latch_set;

  assign tx     = {x_r, 1'b1};
  assign ty     = (y_r == '0) ? X_W'(1) : (y_r - X_W'(1));
  assign two_bb = GRAD_W'({bb_r, 1'b0});
  assign two_aa = GRAD_W'({aa_r, 1'b0});

  // one shared multiplier, operands picked by the command
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      DP_SQ_A: begin
        mul_a = MUL_W'(a_r);
        mul_b = MUL_W'(a_r);
      end
      DP_SQ_B: begin
        mul_a = MUL_W'(y_r);
        mul_b = MUL_W'(y_r);
      end
      DP_AAB: begin
        mul_a = MUL_W'(aa_r);
        mul_b = MUL_W'(y_r);
      end
      DP_TR_LATCH: begin
        mul_a = MUL_W'(tx);
        mul_b = MUL_W'(tx);
      end
      DP_TR_M1: begin
        mul_a = MUL_W'(bb_r);
        mul_b = prod_r[MUL_W-1:0];
      end
      DP_TR_M2: begin
        mul_a = MUL_W'(ty);
        mul_b = MUL_W'(ty);
      end
      DP_TR_M3: begin
        mul_a = MUL_W'(aa_r);
        mul_b = prod_r[MUL_W-1:0];
      end
      DP_TR_M4: begin
        mul_a = MUL_W'(aa_r);
        mul_b = MUL_W'(bb_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // decision register: one wide add per cycle
  always_comb begin
    dec_nxt = dec_r;
    rnd_sum = dec_r;
    case (cmd.op)
      DP_INIT1: dec_nxt = $signed(DEC_W'({bb_r, 2'b00}) + DEC_W'(aa_r));
      DP_INIT2: dec_nxt = dec_r - $signed(DEC_W'({gy_r, 1'b0}));
      DP_RND: begin
        // round half away from zero
        rnd_sum = dec_r + (dec_r[DEC_W-1] ? $signed(DEC_W'(1)) : $signed(DEC_W'(2)));
        dec_nxt = rnd_sum >>> 2;
      end
      DP_TRUNC: begin
        // truncate toward zero
        rnd_sum = dec_r + (dec_r[DEC_W-1] ? $signed(DEC_W'(3)) : $signed(DEC_W'(0)));
        dec_nxt = rnd_sum >>> 2;
      end
      DP_TR_M2: dec_nxt = $signed(prod_r);
      DP_TR_M4: dec_nxt = dec_r + $signed({prod_r[PROD_W-3:0], 2'b00});
      DP_TR_M5: dec_nxt = dec_r - $signed({prod_r[PROD_W-3:0], 2'b00});
      DP_DEC_BB: dec_nxt = dec_r + $signed(DEC_W'(bb_r));
      DP_DEC_AA: begin
        if (dneg_r) begin
          dec_nxt = dec_r + $signed(DEC_W'(aa_r));
        end else begin
          dec_nxt = dec_r - $signed(DEC_W'(aa_r));
        end
      end
      DP_DEC_GX: dec_nxt = dec_r + $signed(DEC_W'(gx_r));
      DP_DEC_GY: dec_nxt = dec_r - $signed(DEC_W'(gy_r));
      default: dec_nxt = dec_r;
    endcase
  end

  assign latch_set = (cmd.op == DP_R1_MOVE) || (cmd.op == DP_TR_LATCH) ||
                     (cmd.op == DP_LATCH);

  always_ff @(posedge clk) begin
    dec_r <= dec_nxt;
    case (cmd.op)
      DP_LOAD: begin
        a_r  <= in_data.semi_major[G-1:0];
        y_r  <= X_W'(in_data.semi_minor[G-1:0]);
        cx_r <= in_data.center_x[G-1:0];
        cy_r <= in_data.center_y[G-1:0];
        x_r  <= '0;
        gx_r <= '0;
      end
      DP_SQ_A, DP_TR_LATCH, DP_TR_M1, DP_TR_M2, DP_TR_M3, DP_TR_M4: begin
        prod_r <= mul_p;
      end
      DP_SQ_B: begin
        aa_r   <= prod_r[AA_W-1:0];
        prod_r <= mul_p;
      end
      DP_AAB: begin
        bb_r   <= prod_r[AA_W-1:0];
        prod_r <= mul_p;
      end
      DP_INIT1: gy_r <= {prod_r[GRAD_W-2:0], 1'b0};
      DP_R1_MOVE: begin
        dneg_r <= dec_r[DEC_W-1];
        x_r    <= x_r + X_W'(1);
        gx_r   <= gx_r + two_bb;
        if (!dec_r[DEC_W-1]) begin
          y_r  <= y_r - X_W'(1);
          gy_r <= gy_r - two_aa;
        end
      end
      DP_R2_MOVE: begin
        dneg_r <= dec_r[DEC_W-1];
        y_r    <= y_r - X_W'(1);
        gy_r   <= gy_r - two_aa;
        if (dec_r[DEC_W-1]) begin
          x_r  <= x_r + X_W'(1);
          gx_r <= gx_r + two_bb;
        end
      end
      default: begin
      end
    endcase

    // capture the symmetric set from the current point
    if (latch_set) begin
      xp_r   <= 12'(cx_r) + 12'(x_r);
      xm_r   <= 12'(cx_r) - 12'(x_r);
      yp_r   <= 12'(cy_r) + 12'(y_r);
      ym_r   <= 12'(cy_r) - 12'(y_r);
      done_r <= (cmd.op != DP_R1_MOVE) && (y_r == '0);
    end

    if (cmd.emit) begin
      out_data_r.last_of_set <= (cmd.idx == 2'd3);
      out_data_r.done_res    <= done_r;
      out_data_r.pixel_x     <= cmd.idx[0] ? $signed(xm_r) : $signed(xp_r);
      out_data_r.pixel_y     <= cmd.idx[1] ? $signed(ym_r) : $signed(yp_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.gx_lt_gy = (gx_r < gy_r);
  assign status.dec_neg  = dneg_r;
  assign status.y_zero   = (y_r == '0);
  assign status.set_done = done_r;
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/mer_ctrl.sv]
// Controller of the ellipse rasterizer: sequences start, region steps and output of each set.
module mer_ctrl import mer_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_op,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;
  region_t     region_r, region_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      region_r <= RG_NONE;
    end else begin
      state_r  <= state_nxt;
      region_r <= region_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt  = state_r;
    region_nxt = region_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_START) begin
            state_nxt  = ST_SQ_A;
            region_nxt = RG_ONE;
          end else begin
            case (region_r)
              RG_ONE:  state_nxt = ST_R1_CHK;
              RG_TWO:  state_nxt = ST_R2_MOVE;
              default: state_nxt = ST_IDLE;
            endcase
          end
        end
      end
      ST_SQ_A:  state_nxt = ST_SQ_B;
      ST_SQ_B:  state_nxt = ST_AAB;
      ST_AAB:   state_nxt = ST_INIT1;
      ST_INIT1: state_nxt = ST_INIT2;
      ST_INIT2: state_nxt = ST_RND;
      ST_RND:   state_nxt = ST_IDLE;
      ST_R1_CHK: state_nxt = status.gx_lt_gy ? ST_R1_BB : ST_TR_M1;
      ST_R1_BB:  state_nxt = ST_R1_GX;
      ST_R1_GX:  state_nxt = status.dec_neg ? ST_EMIT0 : ST_R1_GY;
      ST_R1_GY:  state_nxt = ST_EMIT0;
      ST_TR_M1:  state_nxt = ST_TR_M2;
      ST_TR_M2:  state_nxt = ST_TR_M3;
      ST_TR_M3:  state_nxt = ST_TR_M4;
      ST_TR_M4:  state_nxt = ST_TR_M5;
      ST_TR_M5:  state_nxt = ST_TR_TRUNC;
      ST_TR_TRUNC: begin
        state_nxt  = ST_EMIT0;
        region_nxt = status.set_done ? RG_NONE : RG_TWO;
      end
      ST_R2_MOVE: state_nxt = ST_R2_AA;
      ST_R2_AA:   state_nxt = status.dec_neg ? ST_R2_GX : ST_R2_GY;
      ST_R2_GX:   state_nxt = ST_R2_GY;
      ST_R2_GY:   state_nxt = ST_LATCH;
      ST_LATCH: begin
        state_nxt  = ST_EMIT0;
        region_nxt = status.y_zero ? RG_NONE : RG_TWO;
      end
      ST_EMIT0: state_nxt = status.out_free ? ST_EMIT1 : ST_EMIT0;
      ST_EMIT1: state_nxt = status.out_free ? ST_EMIT2 : ST_EMIT1;
      ST_EMIT2: state_nxt = status.out_free ? ST_EMIT3 : ST_EMIT2;
      ST_EMIT3: state_nxt = status.out_free ? ST_IDLE : ST_EMIT3;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.op   = DP_NOP;
    cmd.emit = 1'b0;
    cmd.idx  = 2'd0;
    in_stall = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_op == OP_START)) begin
          cmd.op = DP_LOAD;
        end
      end
      ST_SQ_A:     cmd.op = DP_SQ_A;
      ST_SQ_B:     cmd.op = DP_SQ_B;
      ST_AAB:      cmd.op = DP_AAB;
      ST_INIT1:    cmd.op = DP_INIT1;
      ST_INIT2:    cmd.op = DP_INIT2;
      ST_RND:      cmd.op = DP_RND;
      ST_R1_CHK:   cmd.op = status.gx_lt_gy ? DP_R1_MOVE : DP_TR_LATCH;
      ST_R1_BB:    cmd.op = DP_DEC_BB;
      ST_R1_GX:    cmd.op = DP_DEC_GX;
      ST_R1_GY:    cmd.op = DP_DEC_GY;
      ST_TR_M1:    cmd.op = DP_TR_M1;
      ST_TR_M2:    cmd.op = DP_TR_M2;
      ST_TR_M3:    cmd.op = DP_TR_M3;
      ST_TR_M4:    cmd.op = DP_TR_M4;
      ST_TR_M5:    cmd.op = DP_TR_M5;
      ST_TR_TRUNC: cmd.op = DP_TRUNC;
      ST_R2_MOVE:  cmd.op = DP_R2_MOVE;
      ST_R2_AA:    cmd.op = DP_DEC_AA;
      ST_R2_GX:    cmd.op = DP_DEC_GX;
      ST_R2_GY:    cmd.op = DP_DEC_GY;
      ST_LATCH:    cmd.op = DP_LATCH;
      ST_EMIT0: begin
        cmd.emit = status.out_free;
        cmd.idx  = 2'd0;
      end
      ST_EMIT1: begin
        cmd.emit = status.out_free;
        cmd.idx  = 2'd1;
      end
      ST_EMIT2: begin
        cmd.emit = status.out_free;
        cmd.idx  = 2'd2;
      end
      ST_EMIT3: begin
        cmd.emit = status.out_free;
        cmd.idx  = 2'd3;
      end
      default: cmd.op = DP_NOP;
    endcase
  end

endmodule

[sv/midpoint_ellipse_rasterizer.sv]
// Midpoint ellipse rasterizer: start items load the geometry, step items emit four-point sets.
// A start item runs the squares and a^2*b through one shared multiplier, then forms the
// rounded start decision, and emits nothing. In a step the decision value goes through one
// wide adder a term per cycle, the transition start value through the shared multiplier over
// five products, and the four points leave through one output register, one per cycle while
// the output is not stalled. The next item is taken once the fourth point sits in that
// register. A step while no ellipse is active is taken in idle and emits nothing.
module midpoint_ellipse_rasterizer import mer_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mer_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mer_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
